// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tm_pkg
// Types and constants shared by the triangle measurement pipeline.
// ----------------------------------------------------------------------------
package tm_pkg;

    localparam int MW           = 64;   // wrap width of products and sums
    localparam int SIDE_W       = 17;
    localparam int PERIM_W      = 19;
    localparam int AREA_W       = 31;
    localparam int ANG_W        = 8;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = 34;
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int IDX_W        = $clog2(CORDIC_STEPS);
    localparam int NORM_MSB     = 40;
    localparam int CW           = 44;   // CORDIC x/y width
    localparam int ZW           = 33;   // CORDIC angle accumulator width
    localparam int PIPE_DEPTH   = 32;   // stages of the square root and CORDIC units

    localparam logic [ANG_W-1:0] ANG_ZERO     = ANG_W'(0);
    localparam logic [ANG_W-1:0] ANG_45       = ANG_W'(45);
    localparam logic [ANG_W-1:0] ANG_RIGHT    = ANG_W'(90);
    localparam logic [ANG_W-1:0] ANG_135      = ANG_W'(135);
    localparam logic [ANG_W-1:0] ANG_STRAIGHT = ANG_W'(180);

    localparam logic signed [ZW-1:0] Z_MIN  = ZW'(1);
    localparam logic signed [ZW-1:0] Z_MAX  = ZW'((64'd90 << ANG_FRAC) - 64'd1);
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'd180 << ANG_FRAC);

    // atan(2^-i) in units of 2^-24 degree
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        ZW'(754974720), ZW'(445687602), ZW'(235489089), ZW'(119537938),
        ZW'(60000934),  ZW'(30029717),  ZW'(15018523),  ZW'(7509720),
        ZW'(3754917),   ZW'(1877466),   ZW'(938734),    ZW'(469367),
        ZW'(234683),    ZW'(117342),    ZW'(58671),     ZW'(29335),
        ZW'(14668),     ZW'(7334),      ZW'(3667),      ZW'(1833),
        ZW'(917),       ZW'(458),       ZW'(229),       ZW'(115),
        ZW'(57),        ZW'(29),        ZW'(14),        ZW'(7)
    };

    typedef struct packed {
        logic [ANG_W-1:0] preset;
        logic             use_cordic;
        logic             dneg;
    } vtx_ctl_t;

    typedef struct packed {
        vtx_ctl_t [2:0]    vtx;
        logic [AREA_W-1:0] area;
        logic              tri_ok;
        logic              right;
    } side_t;

    typedef struct packed {
        logic [SIDE_W-1:0]  side_a;
        logic [SIDE_W-1:0]  side_b;
        logic [SIDE_W-1:0]  side_c;
        logic [PERIM_W-1:0] perim;
        logic [AREA_W-1:0]  area_val;
        logic [ANG_W-1:0]   angle_at_a;
        logic [ANG_W-1:0]   angle_at_b;
        logic [ANG_W-1:0]   angle_at_c;
        logic               is_valid;
        logic               is_right;
    } res_t;

    typedef struct packed {
        logic [MW-1:0] x;
        logic [MW-1:0] y;
    } pair_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cd_t;

    typedef struct packed {
        logic [MW-1:0]     rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

endpackage

// ===== sv/tm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tm_in_if
// Vertex channel: three points per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tm_in_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, output ready);
endinterface

// ===== sv/tm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tm_out_if
// Result channel: sides, perimeter, area, angles and flags per item.
// ----------------------------------------------------------------------------
interface tm_out_if
    import tm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SIDE_W-1:0]  side_a;
    logic [SIDE_W-1:0]  side_b;
    logic [SIDE_W-1:0]  side_c;
    logic [PERIM_W-1:0] perim;
    logic [AREA_W-1:0]  area_val;
    logic [ANG_W-1:0]   angle_at_a;
    logic [ANG_W-1:0]   angle_at_b;
    logic [ANG_W-1:0]   angle_at_c;
    logic               is_valid;
    logic               is_right;

    modport source (output valid, side_a, side_b, side_c, perim, area_val,
                    angle_at_a, angle_at_b, angle_at_c, is_valid, is_right,
                    input ready);
    modport sink   (input valid, side_a, side_b, side_c, perim, area_val,
                    angle_at_a, angle_at_b, angle_at_c, is_valid, is_right,
                    output ready);
endinterface

// ===== sv/tm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tm_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module tm_isqrt
    import tm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MW-1:0]     rad,
    output logic [ROOT_W-1:0] root
);

    function automatic sq_t sq_step(input sq_t s);
        logic [REM_W+1:0] r2;
        logic [REM_W+1:0] t;
        sq_t              o;
        r2    = {s.rem, s.rad[MW-1 -: 2]};
        t     = (REM_W+2)'({s.root, 2'b01});
        o.rad = s.rad << 2;
        if (r2 >= t)
        begin
            o.rem  = REM_W'(r2 - t);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = REM_W'(r2);
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    sq_t init;
    sq_t st_reg [1:ROOT_W];

    assign init = '{rad: rad, rem: '0, root: '0};

    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_stage
        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[k] <= sq_step(init);
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[k] <= sq_step(st_reg[k-1]);
            end
        end
    end

    assign root = st_reg[ROOT_W].root;

endmodule

// ===== sv/tm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tm_cordic
// Pipelined first-quadrant atan(y/x) in 2^-24 degree: three normalize stages,
// one vectoring step per stage, then a clamp stage.
// ----------------------------------------------------------------------------
module tm_cordic
    import tm_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [MW-1:0]        x,
    input  logic [MW-1:0]        y,
    output logic signed [ZW-1:0] z
);

    // shift both left when the top sh bits of x|y are clear
    function automatic pair_t norm_step(input pair_t p, input int unsigned sh);
        pair_t o;
        o = p;
        if (((p.x | p.y) >> (MW - sh)) == '0)
        begin
            o.x = p.x << sh;
            o.y = p.y << sh;
        end
        return o;
    endfunction

    function automatic cd_t cd_step(input cd_t s, input logic [IDX_W-1:0] i);
        logic [CW-1:0]        m;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        cd_t                  o;
        // bias a negative y so the shift truncates toward zero
        m  = ({CW{1'b1}} >> (CW - i)) & {CW{s.y[CW-1]}};
        dx = $signed(s.y + m) >>> i;
        dy = s.x >>> i;
        if (!s.y[CW-1] && (s.y != '0))
        begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + ATAN_TAB[i];
        end
        else
        begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - ATAN_TAB[i];
        end
        return o;
    endfunction

    pair_t                n1_reg;
    pair_t                n2_reg;
    pair_t                n3;
    cd_t                  cd_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg <= norm_step(norm_step('{x: x, y: y}, 32), 16);
            n2_reg <= norm_step(norm_step(n1_reg, 8), 4);
        end
    end

    assign n3 = norm_step(norm_step(n2_reg, 2), 1);

    // msb now at bit 63: keep the top bits so the max lies in [2^40, 2^41)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg[0].x <= CW'({1'b0, n3.x[MW-1 -: NORM_MSB+1]});
            cd_reg[0].y <= CW'({1'b0, n3.y[MW-1 -: NORM_MSB+1]});
            cd_reg[0].z <= '0;
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
                cd_reg[k] <= cd_step(cd_reg[k-1], IDX_W'(k-1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (cd_reg[CORDIC_STEPS].z < Z_MIN)
                z_reg <= Z_MIN;
            else if (cd_reg[CORDIC_STEPS].z > Z_MAX)
                z_reg <= Z_MAX;
            else
                z_reg <= cd_reg[CORDIC_STEPS].z;
        end
    end

    assign z = z_reg;

endmodule

// ===== sv/triangle_measures.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_measures
// Sides, perimeter, area, angles and flags of an integer-grid triangle.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | handshake
//  vtx     | in  | a_x a_y b_x b_y c_x c_y                        | valid/ready
//  res     | out | side_a..c perim area_val angle_at_a..c flags   | valid/ready
//
// One item per cycle while the skid is empty; from accept to res.valid an item
// passes four front stages (differences, products, sums, classify), 32 stages
// of the square root and CORDIC units, and the output register.
// The output register has a one-item skid behind it; the pipeline freezes only
// while the skid holds an item, and vtx.ready drops as soon as the skid fills.
// Reset clears the valid bits; the datapath needs no reset.
// ----------------------------------------------------------------------------
module triangle_measures
    import tm_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    tm_in_if.sink    vtx,
    tm_out_if.source res
);

`include "assert_macros.svh"

    localparam int DW   = COORD_BITS + 1;
    localparam int PRW  = 2 * DW;
    localparam int LAST = 4 + PIPE_DEPTH;

    function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
        return v[MW-1] ? (~v + MW'(1)) : v;
    endfunction

    function automatic vtx_ctl_t classify(input logic zero_edge, input logic [MW-1:0] cm,
                                          input logic [MW-1:0] dm, input logic dneg);
        vtx_ctl_t c;
        c.dneg       = dneg;
        c.use_cordic = 1'b0;
        priority if (zero_edge)
            c.preset = ANG_ZERO;
        else if (cm == '0)
            c.preset = dneg ? ANG_STRAIGHT : ANG_ZERO;
        else if (dm == '0)
            c.preset = ANG_RIGHT;
        else if (cm == dm)
            c.preset = dneg ? ANG_135 : ANG_45;
        else
        begin
            c.preset     = ANG_ZERO;
            c.use_cordic = 1'b1;
        end
        return c;
    endfunction

    function automatic logic [ANG_W-1:0] finish_angle(input vtx_ctl_t c,
                                                      input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        t = c.dneg ? (Z_HALF - z) : z;
        return c.use_cordic ? t[ANG_FRAC +: ANG_W] : c.preset;
    endfunction

    logic en;
    logic last_vld;
    logic vld_reg [1:LAST];

    // stage 1: edge vectors
    logic signed [DW-1:0] ab_x_reg, ab_y_reg, ac_x_reg, ac_y_reg;
    logic signed [DW-1:0] bc_x_reg, bc_y_reg, ba_x_reg, ba_y_reg;
    // stage 2: products
    logic signed [PRW-1:0] sq_abx_reg, sq_aby_reg, sq_acx_reg, sq_acy_reg;
    logic signed [PRW-1:0] sq_bcx_reg, sq_bcy_reg, cr_p_reg, cr_q_reg;
    logic signed [PRW-1:0] da_p_reg, da_q_reg, db_p_reg, db_q_reg, dc_p_reg, dc_q_reg;
    logic                  z_ab2_reg, z_ac2_reg, z_bc2_reg;
    // stage 3: sums, wrapped to 64 bits
    logic [MW-1:0] sa3_reg, sb3_reg, sc3_reg, cr3_reg, da3_reg, db3_reg, dc3_reg;
    logic          z_ab3_reg, z_ac3_reg, z_bc3_reg;
    // stage 4: magnitudes and case selection
    logic [MW-1:0] cm, dma, dmb, dmc;
    logic [MW-1:0] sa4_reg, sb4_reg, sc4_reg, cm4_reg, dma4_reg, dmb4_reg, dmc4_reg;
    side_t         side4;
    side_t         side_reg [0:PIPE_DEPTH];

    logic [ROOT_W-1:0]    la, lb, lc;
    logic signed [ZW-1:0] za, zb, zc;

    res_t res_next;
    res_t res_reg;
    res_t skid_reg;
    logic res_vld_reg;
    logic skid_vld_reg;

    assign en        = !skid_vld_reg;
    assign vtx.ready = en;
    assign last_vld  = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= vtx.valid;
            for (int k = 2; k <= LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_x_reg <= DW'(vtx.b_x) - DW'(vtx.a_x);
            ab_y_reg <= DW'(vtx.b_y) - DW'(vtx.a_y);
            ac_x_reg <= DW'(vtx.c_x) - DW'(vtx.a_x);
            ac_y_reg <= DW'(vtx.c_y) - DW'(vtx.a_y);
            bc_x_reg <= DW'(vtx.c_x) - DW'(vtx.b_x);
            bc_y_reg <= DW'(vtx.c_y) - DW'(vtx.b_y);
            ba_x_reg <= DW'(vtx.a_x) - DW'(vtx.b_x);
            ba_y_reg <= DW'(vtx.a_y) - DW'(vtx.b_y);

            sq_abx_reg <= ab_x_reg * ab_x_reg;
            sq_aby_reg <= ab_y_reg * ab_y_reg;
            sq_acx_reg <= ac_x_reg * ac_x_reg;
            sq_acy_reg <= ac_y_reg * ac_y_reg;
            sq_bcx_reg <= bc_x_reg * bc_x_reg;
            sq_bcy_reg <= bc_y_reg * bc_y_reg;
            cr_p_reg   <= ab_x_reg * ac_y_reg;
            cr_q_reg   <= ab_y_reg * ac_x_reg;
            da_p_reg   <= ab_x_reg * ac_x_reg;
            da_q_reg   <= ab_y_reg * ac_y_reg;
            db_p_reg   <= bc_x_reg * ba_x_reg;
            db_q_reg   <= bc_y_reg * ba_y_reg;
            dc_p_reg   <= ac_x_reg * bc_x_reg;
            dc_q_reg   <= ac_y_reg * bc_y_reg;
            z_ab2_reg  <= (ab_x_reg == '0) && (ab_y_reg == '0);
            z_ac2_reg  <= (ac_x_reg == '0) && (ac_y_reg == '0);
            z_bc2_reg  <= (bc_x_reg == '0) && (bc_y_reg == '0);

            sa3_reg   <= MW'(sq_bcx_reg) + MW'(sq_bcy_reg);
            sb3_reg   <= MW'(sq_acx_reg) + MW'(sq_acy_reg);
            sc3_reg   <= MW'(sq_abx_reg) + MW'(sq_aby_reg);
            cr3_reg   <= MW'(cr_p_reg) - MW'(cr_q_reg);
            da3_reg   <= MW'(da_p_reg) + MW'(da_q_reg);
            db3_reg   <= MW'(db_p_reg) + MW'(db_q_reg);
            dc3_reg   <= MW'(dc_p_reg) + MW'(dc_q_reg);
            z_ab3_reg <= z_ab2_reg;
            z_ac3_reg <= z_ac2_reg;
            z_bc3_reg <= z_bc2_reg;
        end
    end

    // the cross product is the same at every vertex
    always_comb
    begin
        cm  = mag(cr3_reg);
        dma = mag(da3_reg);
        dmb = mag(db3_reg);
        dmc = mag(dc3_reg);
        side4.vtx[0] = classify(z_ab3_reg || z_ac3_reg, cm, dma, da3_reg[MW-1]);
        side4.vtx[1] = classify(z_bc3_reg || z_ab3_reg, cm, dmb, db3_reg[MW-1]);
        side4.vtx[2] = classify(z_ac3_reg || z_bc3_reg, cm, dmc, dc3_reg[MW-1]);
        side4.area   = cm[AREA_W:1];
        side4.tri_ok = (cm != '0);
        side4.right  = (sa3_reg + sb3_reg == sc3_reg) || (sb3_reg + sc3_reg == sa3_reg)
                    || (sc3_reg + sa3_reg == sb3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa4_reg     <= sa3_reg;
            sb4_reg     <= sb3_reg;
            sc4_reg     <= sc3_reg;
            cm4_reg     <= cm;
            dma4_reg    <= dma;
            dmb4_reg    <= dmb;
            dmc4_reg    <= dmc;
            side_reg[0] <= side4;
            for (int k = 1; k <= PIPE_DEPTH; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    tm_isqrt u_sqrt_a (.clk(clk), .en(en), .rad(sa4_reg), .root(la));
    tm_isqrt u_sqrt_b (.clk(clk), .en(en), .rad(sb4_reg), .root(lb));
    tm_isqrt u_sqrt_c (.clk(clk), .en(en), .rad(sc4_reg), .root(lc));

    tm_cordic u_cordic_a (.clk(clk), .en(en), .x(dma4_reg), .y(cm4_reg), .z(za));
    tm_cordic u_cordic_b (.clk(clk), .en(en), .x(dmb4_reg), .y(cm4_reg), .z(zb));
    tm_cordic u_cordic_c (.clk(clk), .en(en), .x(dmc4_reg), .y(cm4_reg), .z(zc));

    always_comb
    begin
        res_next.side_a     = la[SIDE_W-1:0];
        res_next.side_b     = lb[SIDE_W-1:0];
        res_next.side_c     = lc[SIDE_W-1:0];
        res_next.perim      = PERIM_W'(la) + PERIM_W'(lb) + PERIM_W'(lc);
        res_next.area_val   = side_reg[PIPE_DEPTH].area;
        res_next.angle_at_a = finish_angle(side_reg[PIPE_DEPTH].vtx[0], za);
        res_next.angle_at_b = finish_angle(side_reg[PIPE_DEPTH].vtx[1], zb);
        res_next.angle_at_c = finish_angle(side_reg[PIPE_DEPTH].vtx[2], zc);
        res_next.is_valid   = side_reg[PIPE_DEPTH].tri_ok;
        res_next.is_right   = side_reg[PIPE_DEPTH].right;
    end

    // output register with a one-item skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!res_vld_reg || res.ready)
        begin
            res_vld_reg  <= skid_vld_reg || last_vld;
            skid_vld_reg <= 1'b0;
        end
        else if (last_vld && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!res_vld_reg || res.ready)
            res_reg <= skid_vld_reg ? skid_reg : res_next;
        else if (last_vld && en)
            skid_reg <= res_next;
    end

    assign res.valid      = res_vld_reg;
    assign res.side_a     = res_reg.side_a;
    assign res.side_b     = res_reg.side_b;
    assign res.side_c     = res_reg.side_c;
    assign res.perim      = res_reg.perim;
    assign res.area_val   = res_reg.area_val;
    assign res.angle_at_a = res_reg.angle_at_a;
    assign res.angle_at_b = res_reg.angle_at_b;
    assign res.angle_at_c = res_reg.angle_at_c;
    assign res.is_valid   = res_reg.is_valid;
    assign res.is_right   = res_reg.is_right;

    `ASSERT_NEXT(a_skid_fill, clk, rst_n, res.valid && !res.ready && last_vld && !skid_vld_reg, skid_vld_reg, "finished item not parked in skid")
    `ASSERT_IMPLIES(a_skid_blocks_in, clk, rst_n, skid_vld_reg, !vtx.ready, "input open while skid is full")
    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_vld_reg, res_vld_reg, "skid holds an item with output empty")
    `ASSERT_IMPLIES(a_flat_area, clk, rst_n, res.valid && !res.is_valid, res.area_val == '0, "collinear item with nonzero area")

endmodule

// ===== verif/triangle_measures_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_measures_tb
// Feeds integer-grid triangles into triangle_measures and checks every result
// field against a local prediction of sides, perimeter, area, angles and flags.
// Random sender bursts and receiver stalls, including one long receiver
// hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module triangle_measures_tb
    import tm_pkg::*;
();

    localparam int CB         = 16;
    localparam int N_RANDOM   = 1630;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 80;

    typedef struct packed {
        logic signed [CB-1:0] ax;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] bx;
        logic signed [CB-1:0] by;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
    } tri_t;

    logic clk;
    logic rst_n;

    tm_in_if #(.COORD_BITS(CB)) vtx ();
    tm_out_if res ();

    triangle_measures #(.COORD_BITS(CB)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx.sink),
        .res   (res.source)
    );

    tri_t tri_pending[$];
    res_t meas_expected[$];
    tri_t cur_tri;
    int   accepted_cnt;
    int   result_cnt;
    int   mismatch_cnt;
    int   right_seen;
    int   degen_seen;
    int   burst_left;
    int   gap_left;
    int   cycle_cnt;
    int   stall_mode;
    int   mode_left;
    int   hold_left;
    bit   hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- prediction ----------------

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint shift_toward_zero(longint v, int s);
        longint unsigned m;
        if (v < 0)
        begin
            m = -v;
            return -longint'(m >> s);
        end
        m = v;
        return longint'(m >> s);
    endfunction

    // first-quadrant angle of (x, y) in 2^-24 degree units
    function automatic longint cordic_angle(longint unsigned x, longint unsigned y);
        longint xr;
        longint yr;
        longint zr;
        longint dx;
        longint dy;
        while ((x | y) >= (64'd1 << 41))
        begin
            x = x >> 1;
            y = y >> 1;
        end
        while ((x | y) < (64'd1 << 40))
        begin
            x = x << 1;
            y = y << 1;
        end
        xr = x;
        yr = y;
        zr = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = shift_toward_zero(yr, i);
            dy = shift_toward_zero(xr, i);
            if (yr > 0)
            begin
                xr = xr + dx;
                yr = yr - dy;
                zr = zr + longint'(ATAN_TAB[i]);
            end
            else
            begin
                xr = xr - dx;
                yr = yr + dy;
                zr = zr - longint'(ATAN_TAB[i]);
            end
        end
        if (zr < 1)
            zr = 1;
        if (zr > (longint'(90) << ANG_FRAC) - 1)
            zr = (longint'(90) << ANG_FRAC) - 1;
        return zr;
    endfunction

    function automatic logic [ANG_W-1:0] corner_angle(longint px, longint py, longint qx,
                                                      longint qy, longint rx, longint ry);
        longint ux;
        longint uy;
        longint vx;
        longint vy;
        longint cr;
        longint dt;
        longint unsigned cm;
        longint unsigned dm;
        longint zr;
        ux = qx - px;
        uy = qy - py;
        vx = rx - px;
        vy = ry - py;
        if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0))
            return ANG_ZERO;
        cr = ux * vy - uy * vx;
        dt = ux * vx + uy * vy;
        cm = (cr < 0) ? -cr : cr;
        dm = (dt < 0) ? -dt : dt;
        if (cm == 0)
            return (dt < 0) ? ANG_STRAIGHT : ANG_ZERO;
        if (dm == 0)
            return ANG_RIGHT;
        if (cm == dm)
            return (dt < 0) ? ANG_135 : ANG_45;
        zr = cordic_angle(dm, cm);
        if (dt < 0)
            return ANG_W'(((longint'(180) << ANG_FRAC) - zr) >>> ANG_FRAC);
        return ANG_W'(zr >>> ANG_FRAC);
    endfunction

    function automatic res_t predict_measures(tri_t t);
        res_t r;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint cx;
        longint cy;
        longint unsigned sa;
        longint unsigned sb;
        longint unsigned sc;
        longint unsigned la;
        longint unsigned lb;
        longint unsigned lc;
        longint cr;
        longint unsigned cm;
        ax = t.ax;
        ay = t.ay;
        bx = t.bx;
        by = t.by;
        cx = t.cx;
        cy = t.cy;
        sa = (cx - bx) * (cx - bx) + (cy - by) * (cy - by);
        sb = (ax - cx) * (ax - cx) + (ay - cy) * (ay - cy);
        sc = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
        la = floor_root(sa);
        lb = floor_root(sb);
        lc = floor_root(sc);
        cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        cm = (cr < 0) ? -cr : cr;
        r.side_a     = SIDE_W'(la);
        r.side_b     = SIDE_W'(lb);
        r.side_c     = SIDE_W'(lc);
        r.perim      = PERIM_W'(la + lb + lc);
        r.area_val   = AREA_W'(cm >> 1);
        r.angle_at_a = corner_angle(ax, ay, bx, by, cx, cy);
        r.angle_at_b = corner_angle(bx, by, cx, cy, ax, ay);
        r.angle_at_c = corner_angle(cx, cy, ax, ay, bx, by);
        r.is_valid   = (cm != 0);
        r.is_right   = (sa + sb == sc) || (sb + sc == sa) || (sc + sa == sb);
        return r;
    endfunction

    // ---------------- stimulus ----------------

    task automatic add_tri(int ax, int ay, int bx, int by, int cx, int cy);
        tri_t t;
        t.ax = CB'(ax);
        t.ay = CB'(ay);
        t.bx = CB'(bx);
        t.by = CB'(by);
        t.cx = CB'(cx);
        t.cy = CB'(cy);
        tri_pending.push_back(t);
    endtask

    function automatic int pick_coord(int kind);
        case (kind)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 24)) - 12;
            2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic add_random_tri();
        int kind;
        int ax;
        int ay;
        int px;
        int py;
        int k;
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            // right triangle: perpendicular legs from A, optionally reordered
            ax = pick_coord(3);
            ay = pick_coord(3);
            px = int'($urandom_range(0, 200)) - 100;
            py = int'($urandom_range(0, 200)) - 100;
            k = $urandom_range(1, 3);
            if (kind == 0)
                add_tri(ax, ay, ax + px, ay + py, ax - k * py, ay + k * px);
            else
                add_tri(ax + px, ay + py, ax - k * py, ay + k * px, ax, ay);
        end
        else if (kind == 3)
        begin
            // collinear points, often with a repeated vertex
            ax = pick_coord(3);
            ay = pick_coord(3);
            px = int'($urandom_range(0, 40)) - 20;
            py = int'($urandom_range(0, 40)) - 20;
            k = int'($urandom_range(0, 6)) - 3;
            add_tri(ax, ay, ax + px, ay + py, ax + k * px, ay + k * py);
        end
        else if (kind == 4)
            add_tri(pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1),
                    pick_coord(1), pick_coord(1));
        else if (kind == 5)
            add_tri(pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2),
                    pick_coord(0), pick_coord(0));
        else
            add_tri(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0),
                    pick_coord(0), pick_coord(0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        add_tri(0, 0, 0, 0, 0, 0);                          // three equal points
        add_tri(5, 5, 5, 5, 8, 9);                          // A on B
        add_tri(0, 0, 10, 0, 20, 0);                        // collinear, straight angle
        add_tri(0, 0, 3, 0, 0, 4);                          // 3-4-5 right angle
        add_tri(0, 0, 10, 0, 10, 10);                       // 45 degree corners
        add_tri(0, 0, 10, 10, -10, 0);                      // 135 degree corner
        add_tri(0, 0, 4, 0, 2, 3);                          // acute, needs CORDIC
        add_tri(0, 0, 100, 0, -1, 1);                       // 135 at A, thin at B
        add_tri(-32768, -32768, 32767, 32767, -32768, 32767);
        add_tri(-32768, -32768, 32767, -32768, 32767, 32767);
        add_tri(32767, 32767, -32768, -32768, 32767, -32768);
        add_tri(-32768, -32768, 32767, 32767, 0, 0);        // long collinear
        add_tri(-32768, 0, 32767, 0, 0, 1);                 // thin sliver
        add_tri(-32768, -32768, -32768, -32768, 32767, 32767);
        add_tri(1, 0, 0, 1, -1, 0);                         // right angle at B
        add_tri(0, 0, 1, 1, 2, 0);
        add_tri(7, -3, -2, 11, 7, -3);                      // C on A
        add_tri(0, 0, 1000, 1, 1, 1000);                    // near right
        add_tri(-1, -1, -1, -1, -1, -1);
        for (int i = 0; i < N_RANDOM; i++)
            add_random_tri();

        wait (tri_pending.size() == 0 && !vtx.valid);
        wait (meas_expected.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Checked %0d results from %0d triangles (%0d right, %0d degenerate);",
                 result_cnt, accepted_cnt, right_seen, degen_seen);
        $display("covered grid extremes, collinear and repeated vertices, bursts and stalls.");
        if (mismatch_cnt == 0 && result_cnt == accepted_cnt)
            $display("triangle_measures_tb: PASS");
        else
            $display("triangle_measures_tb: FAIL");
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx.valid    <= 1'b0;
            vtx.a_x      <= '0;
            vtx.a_y      <= '0;
            vtx.b_x      <= '0;
            vtx.b_y      <= '0;
            vtx.c_x      <= '0;
            vtx.c_y      <= '0;
            accepted_cnt <= 0;
            burst_left   <= 8;
            gap_left     <= 0;
        end
        else
        begin
            if (vtx.valid && vtx.ready)
            begin
                meas_expected.push_back(predict_measures(cur_tri));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!vtx.valid || vtx.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    vtx.valid <= 1'b0;
                end
                else if (tri_pending.size() > 0)
                begin
                    cur_tri = tri_pending.pop_front();
                    vtx.a_x   <= cur_tri.ax;
                    vtx.a_y   <= cur_tri.ay;
                    vtx.b_x   <= cur_tri.bx;
                    vtx.b_y   <= cur_tri.by;
                    vtx.c_x   <= cur_tri.cx;
                    vtx.c_y   <= cur_tri.cy;
                    vtx.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 60);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    vtx.valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 50;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(10, 120);
            end
            else
                mode_left <= mode_left - 1;

            // hold off once for long enough that the pipeline and skid fill up
            if (!hold_done && accepted_cnt >= 400)
            begin
                hold_done <= 1'b1;
                hold_left <= 200;
                res.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= ($urandom_range(0, 1) != 0);
                    2: res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // ---------------- monitor ----------------

    task automatic check_field(string fname, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                         result_cnt, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            result_cnt   <= 0;
            mismatch_cnt = 0;
            right_seen   <= 0;
            degen_seen   <= 0;
        end
        else if (res.valid && res.ready)
        begin
            if (meas_expected.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("Unexpected result with nothing pending");
            end
            else
            begin
                want = meas_expected.pop_front();
                check_field("side_a", want.side_a, res.side_a);
                check_field("side_b", want.side_b, res.side_b);
                check_field("side_c", want.side_c, res.side_c);
                check_field("perim", want.perim, res.perim);
                check_field("area_val", want.area_val, res.area_val);
                check_field("angle_at_a", want.angle_at_a, res.angle_at_a);
                check_field("angle_at_b", want.angle_at_b, res.angle_at_b);
                check_field("angle_at_c", want.angle_at_c, res.angle_at_c);
                check_field("is_valid", want.is_valid, res.is_valid);
                check_field("is_right", want.is_right, res.is_right);
                if (want.is_right)
                    right_seen <= right_seen + 1;
                if (!want.is_valid)
                    degen_seen <= degen_seen + 1;
            end
            result_cnt <= result_cnt + 1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_cnt <= 0;
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt >= CYCLE_CAP)
            begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycle_cnt, meas_expected.size());
                $display("triangle_measures_tb: FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tm_pkg.sv
sv/tm_in_if.sv
sv/tm_out_if.sv
sv/tm_isqrt.sv
sv/tm_cordic.sv
sv/triangle_measures.sv
verif/triangle_measures_tb.sv
